// ===== rtl/rcam_pkg.sv =====
// Shared types, constants and helpers for the rounded corner alpha mask.
`default_nettype none

package rcam_pkg;

    // Subsample grid and fixed-point scale of the corner test.
    localparam int SUB        = 8;
    localparam int SUB_COUNT  = SUB * SUB;
    localparam int SCALE_SH   = $clog2(2 * SUB);
    localparam int COUNT_SH   = $clog2(SUB_COUNT);

    // Frame limits and field widths.
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int RAD_W      = 12;
    localparam int COORD_W    = 12;
    localparam int UNIT_W     = COORD_W + SCALE_SH;
    localparam int SPAN_W     = DIM_W + SCALE_SH;
    localparam int DIST_W     = UNIT_W;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int ROW_CNT_W  = $clog2(SUB + 1);
    localparam int COV_W      = $clog2(SUB_COUNT + 1);
    localparam int ALPHA_NUM_W = COV_W + 8;

    // Register indexes (byte address bits 3:2).
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CORNER_RADIUS = 2'd2
    } reg_index_t;

    // Effective geometry derived from the configuration registers.
    typedef struct packed {
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [RAD_W-1:0]  r;
        logic [UNIT_W-1:0] ru;
        logic [SPAN_W-1:0] rc;
        logic [SPAN_W-1:0] bc;
        logic [SQ_W-1:0]   rsq;
    } geo_t;

    // Load enables for the subsample stages.
    typedef struct packed {
        logic load_b;
        logic load_c;
        logic load_d;
    } stage_en_t;

    // Covered subsample count of each grid row.
    typedef logic [SUB-1:0][ROW_CNT_W-1:0] row_cnt_t;

    // Exact v / 255, rounded down, for any 16-bit v below 65280.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rounded_corner_alpha_mask_core.sv =====
// Top level of the rounded corner alpha mask: registers, pipeline and output.
//
//  Channel  | Handshake                 | Beat contents
//  ---------+---------------------------+-------------------------------
//  pixel    | pixel_valid / pixel_stall | pixel_in, column, row
//  mask     | mask_valid / mask_stall   | pixel_out
//  config   | APB psel/penable/pready   | frame_width, frame_height, radius
//
// One beat enters per cycle while pixel_stall is low; each beat goes through six
// register stages (input, distances, squares, row counts, alpha, output). Each
// stage holds its beat only while the stage after it is full and held, so a
// stalled output still lets beats in until the pipeline is full. Reset clears
// the valid bits and loads the register reset values; a register write reaches
// the effective sides and radius registers, then the radius square register.
`default_nettype none

module rounded_corner_alpha_mask_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Pixel input
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  wire logic [31:0] pixel_in,
    input  wire logic [11:0] column,
    input  wire logic [11:0] row,
    // Masked pixel output
    output logic             mask_valid,
    input  wire logic        mask_stall,
    output logic [31:0]      pixel_out
);

    logic [rcam_pkg::DIM_W-1:0] frame_width_reg;
    logic [rcam_pkg::DIM_W-1:0] frame_height_reg;
    logic [rcam_pkg::RAD_W-1:0] corner_radius_reg;
    logic [rcam_pkg::DIM_W-1:0] w_eff_next;
    logic [rcam_pkg::DIM_W-1:0] h_eff_next;
    logic [rcam_pkg::RAD_W-1:0] r_eff_next;
    logic [rcam_pkg::DIM_W-1:0] w_eff_reg;
    logic [rcam_pkg::DIM_W-1:0] h_eff_reg;
    logic [rcam_pkg::RAD_W-1:0] r_eff_reg;
    logic [rcam_pkg::SQ_W-1:0]  rsq_reg;
    rcam_pkg::geo_t             geo;
    logic                       cfg_write;
    rcam_pkg::reg_index_t       reg_index;

    logic                       a_valid_reg, b_valid_reg, c_valid_reg;
    logic                       d_valid_reg, e_valid_reg, f_valid_reg;
    logic                       ready_a, ready_b, ready_c, ready_d, ready_e, ready_f;
    logic [31:0]                a_pix_reg, b_pix_reg, c_pix_reg, d_pix_reg, e_pix_reg;
    logic [rcam_pkg::COORD_W-1:0] a_x_reg;
    logic [rcam_pkg::COORD_W-1:0] a_y_reg;
    rcam_pkg::stage_en_t        stage_en;
    rcam_pkg::row_cnt_t         row_cnt;
    logic                       d_inside;
    logic [rcam_pkg::COV_W-1:0] covered;
    logic [rcam_pkg::ALPHA_NUM_W-1:0] alpha_num;
    logic [7:0]                 alpha_next;
    logic [7:0]                 e_alpha_reg;
    logic [31:0]                pixel_out_next;
    logic [31:0]                pixel_out_reg;

    // Register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = rcam_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= rcam_pkg::DIM_W'(1);
            frame_height_reg  <= rcam_pkg::DIM_W'(1);
            corner_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                rcam_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[rcam_pkg::DIM_W-1:0];
                rcam_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[rcam_pkg::DIM_W-1:0];
                rcam_pkg::REG_CORNER_RADIUS: corner_radius_reg <= pwdata[rcam_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            rcam_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_reg);
            rcam_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            rcam_pkg::REG_CORNER_RADIUS: prdata = 32'(corner_radius_reg);
            default:                     prdata = '0;
        endcase
    end

    // Effective sides saturate at the maximum; the radius is clamped to half
    // the smaller side.
    always_comb
    begin
        logic [rcam_pkg::DIM_W-1:0] min_side;
        logic [rcam_pkg::RAD_W-1:0] half_side;
        w_eff_next = (frame_width_reg > rcam_pkg::DIM_W'(rcam_pkg::MAX_DIM))
                   ? rcam_pkg::DIM_W'(rcam_pkg::MAX_DIM) : frame_width_reg;
        h_eff_next = (frame_height_reg > rcam_pkg::DIM_W'(rcam_pkg::MAX_DIM))
                   ? rcam_pkg::DIM_W'(rcam_pkg::MAX_DIM) : frame_height_reg;
        min_side   = (w_eff_next < h_eff_next) ? w_eff_next : h_eff_next;
        half_side  = rcam_pkg::RAD_W'(min_side >> 1);
        r_eff_next = (corner_radius_reg > half_side) ? half_side : corner_radius_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= rcam_pkg::DIM_W'(1);
            h_eff_reg <= rcam_pkg::DIM_W'(1);
            r_eff_reg <= '0;
            rsq_reg   <= '0;
        end
        else
        begin
            w_eff_reg <= w_eff_next;
            h_eff_reg <= h_eff_next;
            r_eff_reg <= r_eff_next;
            rsq_reg   <= rcam_pkg::SQ_W'(geo.ru) * rcam_pkg::SQ_W'(geo.ru);
        end
    end

    // Corner limits in subsample units.
    always_comb
    begin
        geo.w   = w_eff_reg;
        geo.h   = h_eff_reg;
        geo.r   = r_eff_reg;
        geo.ru  = rcam_pkg::UNIT_W'(r_eff_reg) << rcam_pkg::SCALE_SH;
        geo.rc  = (rcam_pkg::SPAN_W'(w_eff_reg) << rcam_pkg::SCALE_SH)
                - rcam_pkg::SPAN_W'(geo.ru);
        geo.bc  = (rcam_pkg::SPAN_W'(h_eff_reg) << rcam_pkg::SCALE_SH)
                - rcam_pkg::SPAN_W'(geo.ru);
        geo.rsq = rsq_reg;
    end

    // A stage takes a new beat when it is empty or its beat moves on.
    assign ready_f = !f_valid_reg || !mask_stall;
    assign ready_e = !e_valid_reg || ready_f;
    assign ready_d = !d_valid_reg || ready_e;
    assign ready_c = !c_valid_reg || ready_d;
    assign ready_b = !b_valid_reg || ready_c;
    assign ready_a = !a_valid_reg || ready_b;

    assign pixel_stall     = !ready_a;
    assign stage_en.load_b = ready_b;
    assign stage_en.load_c = ready_c;
    assign stage_en.load_d = ready_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a) a_valid_reg <= pixel_valid;
            if (ready_b) b_valid_reg <= a_valid_reg;
            if (ready_c) c_valid_reg <= b_valid_reg;
            if (ready_d) d_valid_reg <= c_valid_reg;
            if (ready_e) e_valid_reg <= d_valid_reg;
            if (ready_f) f_valid_reg <= e_valid_reg;
        end
    end

    // Input register and the color carried alongside the coverage stages.
    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            a_pix_reg <= pixel_in;
            a_x_reg   <= column;
            a_y_reg   <= row;
        end
        if (ready_b) b_pix_reg <= a_pix_reg;
        if (ready_c) c_pix_reg <= b_pix_reg;
        if (ready_d) d_pix_reg <= c_pix_reg;
    end

    rcam_coverage u_coverage (
        .clk     (clk),
        .en      (stage_en),
        .geo     (geo),
        .x       (a_x_reg),
        .y       (a_y_reg),
        .row_cnt (row_cnt),
        .plain   (d_inside)
    );

    // Alpha is the covered fraction scaled to 255, rounded; a plain pixel gets 255.
    always_comb
    begin
        covered = '0;
        for (int j = 0; j < rcam_pkg::SUB; j++)
            covered = covered + rcam_pkg::COV_W'(row_cnt[j]);
        alpha_num  = rcam_pkg::ALPHA_NUM_W'(covered) * rcam_pkg::ALPHA_NUM_W'(255)
                   + rcam_pkg::ALPHA_NUM_W'(rcam_pkg::SUB_COUNT / 2);
        alpha_next = d_inside ? 8'hFF : 8'(alpha_num >> rcam_pkg::COUNT_SH);
    end

    always_ff @(posedge clk)
    begin
        if (ready_e)
        begin
            e_alpha_reg <= alpha_next;
            e_pix_reg   <= d_pix_reg;
        end
    end

    // Premultiply each color channel; alpha 255 leaves the color unchanged.
    always_comb
    begin
        logic [15:0] red_prod;
        logic [15:0] green_prod;
        logic [15:0] blue_prod;
        red_prod   = 16'(e_pix_reg[23:16]) * 16'(e_alpha_reg) + 16'd127;
        green_prod = 16'(e_pix_reg[15:8])  * 16'(e_alpha_reg) + 16'd127;
        blue_prod  = 16'(e_pix_reg[7:0])   * 16'(e_alpha_reg) + 16'd127;
        pixel_out_next = {e_alpha_reg,
                          rcam_pkg::div255(red_prod),
                          rcam_pkg::div255(green_prod),
                          rcam_pkg::div255(blue_prod)};
    end

    always_ff @(posedge clk)
    begin
        if (ready_f)
            pixel_out_reg <= pixel_out_next;
    end

    assign mask_valid = f_valid_reg;
    assign pixel_out  = pixel_out_reg;

    // The clamped radius never exceeds half of either side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (r_eff_reg <= 12'(w_eff_reg >> 1)) && (r_eff_reg <= 12'(h_eff_reg >> 1)))
        else $error("corner radius exceeds half a side");

    // A beat in the row-count stage never covers more than the whole grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (covered <= rcam_pkg::COV_W'(rcam_pkg::SUB_COUNT)))
        else $error("coverage count out of range");

    // A beat accepted into a full input stage requires the next stage to move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall && a_valid_reg) |-> ready_b)
        else $error("input beat overwrites a held beat");

    // The output only fills from a valid alpha stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(f_valid_reg) |-> $past(e_valid_reg))
        else $error("output beat appeared from an empty stage");

endmodule

`default_nettype wire

// ===== rtl/rcam_coverage.sv =====
// Corner subsample test: distances, squares and per-row coverage counts.
`default_nettype none

module rcam_coverage (
    input  wire logic                             clk,
    input  wire rcam_pkg::stage_en_t              en,
    input  wire rcam_pkg::geo_t                   geo,
    input  wire logic [rcam_pkg::COORD_W-1:0]     x,
    input  wire logic [rcam_pkg::COORD_W-1:0]     y,
    output rcam_pkg::row_cnt_t                    row_cnt,
    output logic                                  plain
);

    logic [rcam_pkg::DIST_W-1:0] dx_next [rcam_pkg::SUB];
    logic [rcam_pkg::DIST_W-1:0] dy_next [rcam_pkg::SUB];
    logic [rcam_pkg::DIST_W-1:0] dx_reg  [rcam_pkg::SUB];
    logic [rcam_pkg::DIST_W-1:0] dy_reg  [rcam_pkg::SUB];
    logic [rcam_pkg::SQ_W-1:0]   dx2_reg [rcam_pkg::SUB];
    logic [rcam_pkg::SQ_W-1:0]   dy2_reg [rcam_pkg::SUB];
    logic                        inside_next;
    logic                        b_inside_reg;
    logic                        c_inside_reg;
    logic                        d_inside_reg;
    rcam_pkg::row_cnt_t          row_cnt_next;
    rcam_pkg::row_cnt_t          row_cnt_reg;

    // A pixel is a plain one if the radius is zero or unless both coordinates fall in a corner band.
    always_comb
    begin
        logic [rcam_pkg::DIM_W-1:0] xe;
        logic [rcam_pkg::DIM_W-1:0] ye;
        logic [rcam_pkg::DIM_W-1:0] re;
        xe = rcam_pkg::DIM_W'(x);
        ye = rcam_pkg::DIM_W'(y);
        re = rcam_pkg::DIM_W'(geo.r);
        inside_next = (geo.r == '0)
                   || (xe >= re && xe < geo.w - re)
                   || (ye >= re && ye < geo.h - re);
    end

    // Distance of each subsample center from the corner square, per axis.
    always_comb
    begin
        logic [rcam_pkg::SPAN_W-1:0] xu;
        logic [rcam_pkg::SPAN_W-1:0] yu;
        logic [rcam_pkg::SPAN_W-1:0] rue;
        rue = rcam_pkg::SPAN_W'(geo.ru);
        for (int i = 0; i < rcam_pkg::SUB; i++)
        begin
            xu = (rcam_pkg::SPAN_W'(x) << rcam_pkg::SCALE_SH) | rcam_pkg::SPAN_W'(2 * i + 1);
            yu = (rcam_pkg::SPAN_W'(y) << rcam_pkg::SCALE_SH) | rcam_pkg::SPAN_W'(2 * i + 1);
            if (xu > geo.rc)
                dx_next[i] = rcam_pkg::DIST_W'(xu - geo.rc);
            else if (xu < rue)
                dx_next[i] = rcam_pkg::DIST_W'(rue - xu);
            else
                dx_next[i] = '0;
            if (yu > geo.bc)
                dy_next[i] = rcam_pkg::DIST_W'(yu - geo.bc);
            else if (yu < rue)
                dy_next[i] = rcam_pkg::DIST_W'(rue - yu);
            else
                dy_next[i] = '0;
        end
    end

    // Each subsample inside the circle adds one to its row count.
    always_comb
    begin
        logic [rcam_pkg::SQ_W:0] dist_sq;
        row_cnt_next = '0;
        for (int j = 0; j < rcam_pkg::SUB; j++)
        begin
            for (int i = 0; i < rcam_pkg::SUB; i++)
            begin
                dist_sq = {1'b0, dx2_reg[i]} + {1'b0, dy2_reg[j]};
                if (dist_sq <= {1'b0, geo.rsq})
                    row_cnt_next[j] = row_cnt_next[j] + rcam_pkg::ROW_CNT_W'(1);
            end
        end
    end

    // Stage B: distances. Stage C: squares. Stage D: row counts.
    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            b_inside_reg <= inside_next;
        end
        if (en.load_c)
        begin
            for (int i = 0; i < rcam_pkg::SUB; i++)
            begin
                dx2_reg[i] <= rcam_pkg::SQ_W'(dx_reg[i]) * rcam_pkg::SQ_W'(dx_reg[i]);
                dy2_reg[i] <= rcam_pkg::SQ_W'(dy_reg[i]) * rcam_pkg::SQ_W'(dy_reg[i]);
            end
            c_inside_reg <= b_inside_reg;
        end
        if (en.load_d)
        begin
            row_cnt_reg  <= row_cnt_next;
            d_inside_reg <= c_inside_reg;
        end
    end

    assign row_cnt = row_cnt_reg;
    assign plain   = d_inside_reg;

endmodule

`default_nettype wire

// ===== tb/tb_rounded_corner_alpha_mask_core.sv =====
// Self-checking testbench for the rounded corner alpha mask core.
module tb_rounded_corner_alpha_mask_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Subsample grid of the corner test and the frame size limit.
    localparam int GRID        = 8;
    localparam int GRID_UNIT   = 2 * GRID;
    localparam int GRID_CELLS  = GRID * GRID;
    localparam int FRAME_MAX   = 4096;
    localparam int PIPE_DEPTH  = 6;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_LIMIT = 5000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [31:0] argb;
        logic [11:0] column_pos;
        logic [11:0] row_pos;
    } pixel_beat_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    logic [31:0] pixel_in    = '0;
    logic [11:0] column      = '0;
    logic [11:0] row         = '0;
    logic        mask_valid;
    logic        mask_stall  = 1'b0;
    logic [31:0] pixel_out;

    // Register shadows and the effective geometry derived from them.
    logic [12:0] frame_width_reg   = 13'd1;
    logic [12:0] frame_height_reg  = 13'd1;
    logic [11:0] corner_radius_reg = 12'd0;
    int geo_w = 1;
    int geo_h = 1;
    int geo_r = 0;

    pixel_beat_t pixel_backlog[$];
    logic [31:0] expected_pixels[$];

    logic pix_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int pattern_left = 0;
    stall_mode_t pattern_mode = STALL_NONE;

    int errors = 0;
    int beats_in = 0;
    int results_checked = 0;
    int partial_results = 0;
    int settings_done = 0;
    int cycle_count = 0;

    rounded_corner_alpha_mask_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Premultiply one color channel by alpha with rounded division by 255.
    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] a);
        int unsigned p;
        p = int'(c) * int'(a) + 127;
        return 8'(p / 255);
    endfunction

    // Expected masked pixel for one beat under the current geometry.
    function automatic logic [31:0] mask_pixel(input logic [31:0] pix,
                                               input logic [11:0] col,
                                               input logic [11:0] rw);
        longint x, y, ru, rsq, right, bottom, xu, yu, dx, dy, covered;
        int sx, sy;
        logic [7:0] alpha;
        x = col;
        y = rw;
        if (geo_r == 0 || (x >= geo_r && x < geo_w - geo_r) ||
            (y >= geo_r && y < geo_h - geo_r))
            return {8'hFF, pix[23:0]};
        ru = longint'(geo_r) * GRID_UNIT;
        rsq = ru * ru;
        right = longint'(geo_w) * GRID_UNIT - ru;
        bottom = longint'(geo_h) * GRID_UNIT - ru;
        covered = 0;
        for (sy = 0; sy < GRID; sy++)
        begin
            yu = y * GRID_UNIT + sy * 2 + 1;
            dy = (yu < ru) ? yu - ru : ((yu > bottom) ? yu - bottom : 0);
            for (sx = 0; sx < GRID; sx++)
            begin
                xu = x * GRID_UNIT + sx * 2 + 1;
                dx = (xu < ru) ? xu - ru : ((xu > right) ? xu - right : 0);
                if (dx * dx + dy * dy <= rsq)
                    covered++;
            end
        end
        alpha = 8'((covered * 255 + GRID_CELLS / 2) / GRID_CELLS);
        return {alpha, scale_channel(pix[23:16], alpha), scale_channel(pix[15:8], alpha),
                scale_channel(pix[7:0], alpha)};
    endfunction

    // Coordinate biased toward the corner bands of one axis, sometimes off the frame.
    function automatic logic [11:0] pick_coord(input int span);
        int lo, hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                lo = 0;
                hi = geo_r + 1;
            end
            4, 5, 6:
            begin
                lo = span - geo_r - 2;
                hi = span;
            end
            7:
            begin
                lo = 0;
                hi = 4095;
            end
            8:
            begin
                lo = geo_r;
                hi = span - geo_r - 1;
            end
            default:
            begin
                lo = 4095 * $urandom_range(0, 1);
                hi = lo;
            end
        endcase
        lo = (lo < 0) ? 0 : ((lo > 4095) ? 4095 : lo);
        hi = (hi < 0) ? 0 : ((hi > 4095) ? 4095 : hi);
        if (hi < lo)
            hi = lo;
        return 12'($urandom_range(lo, hi));
    endfunction

    // Sender: bursts of beats with random gaps; a stalled beat is held unchanged.
    always @(negedge clk)
    begin : pixel_driver
        pixel_beat_t beat;
        if (rst_n && (!pixel_valid || pix_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                pixel_valid <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                beat = pixel_backlog.pop_front();
                pixel_in <= beat.argb;
                column <= beat.column_pos;
                row <= beat.row_pos;
                pixel_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // Receiver: a changing stall pattern, plus long holds on request.
    always @(negedge clk)
    begin : mask_receiver
        logic stall_next;
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_mode = stall_mode_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(5, 60);
                end
                pattern_left--;
                case (pattern_mode)
                    STALL_NONE:  stall_next = 1'b0;
                    STALL_LIGHT: stall_next = ($urandom_range(0, 9) < 3);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
                    default:     stall_next = ~mask_stall;
                endcase
            end
            mask_stall <= stall_next;
        end
    end

    // Predict each accepted beat and check each accepted result against the oldest one.
    always @(posedge clk)
    begin : mask_monitor
        logic [31:0] want;
        if (!rst_n)
            pix_taken <= 1'b0;
        else
        begin
            pix_taken <= pixel_valid && !pixel_stall;
            if (pixel_valid && !pixel_stall)
            begin
                expected_pixels.insert(expected_pixels.size(),
                                       mask_pixel(pixel_in, column, row));
                beats_in++;
            end
            if (mask_valid && !mask_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("unexpected result pixel_out=%08h", pixel_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (want[31:24] != 8'h00 && want[31:24] != 8'hFF)
                        partial_results++;
                    if (pixel_out !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("result %0d: pixel_out expected %08h, got %08h",
                                     results_checked, want, pixel_out);
                    end
                end
            end
        end
    end

    // Run-length guard.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_rounded_corner_alpha_mask_core NOT OK");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [31:0] argb, input logic [11:0] col,
                               input logic [11:0] rw);
        pixel_beat_t beat;
        beat.argb = argb;
        beat.column_pos = col;
        beat.row_pos = rw;
        pixel_backlog.insert(pixel_backlog.size(), beat);
    endtask

    // Wait until every beat is sent and every result has come, then let the pipe settle.
    task automatic wait_drained();
        int waited;
        waited = 0;
        do
        begin
            @(posedge clk);
            #1;
            waited++;
        end
        while (!(pixel_backlog.size() == 0 && !pixel_valid && expected_pixels.size() == 0)
               && waited < DRAIN_LIMIT);
        if (expected_pixels.size() > 0)
        begin
            errors += expected_pixels.size();
            $display("%0d expected results never arrived", expected_pixels.size());
            expected_pixels.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input rcam_pkg::reg_index_t idx, input logic [31:0] value);
        int m;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rcam_pkg::REG_FRAME_WIDTH:   frame_width_reg = value[12:0];
            rcam_pkg::REG_FRAME_HEIGHT:  frame_height_reg = value[12:0];
            rcam_pkg::REG_CORNER_RADIUS: corner_radius_reg = value[11:0];
            default: ;
        endcase
        geo_w = (frame_width_reg > FRAME_MAX) ? FRAME_MAX : int'(frame_width_reg);
        geo_h = (frame_height_reg > FRAME_MAX) ? FRAME_MAX : int'(frame_height_reg);
        m = (geo_w < geo_h) ? geo_w : geo_h;
        geo_r = (int'(corner_radius_reg) > m / 2) ? m / 2 : int'(corner_radius_reg);
    endtask

    // New frame geometry, written only once the pipeline is empty.
    task automatic configure(input int w, input int h, input int r);
        wait_drained();
        write_register(rcam_pkg::REG_FRAME_WIDTH, 32'(w));
        write_register(rcam_pkg::REG_FRAME_HEIGHT, 32'(h));
        write_register(rcam_pkg::REG_CORNER_RADIUS, 32'(r));
        repeat (3) @(posedge clk);
        settings_done++;
    endtask

    // One random phase: a geometry, then corner-heavy beats with random colors.
    task automatic run_phase(input int w, input int h, input int r, input int n,
                             input bit long_hold);
        int i;
        configure(w, h, r);
        for (i = 0; i < n; i++)
            queue_pixel($urandom(), pick_coord(geo_w), pick_coord(geo_h));
        if (long_hold)
            hold_requests++;
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry: no rounding, every pixel is opaque.
        queue_pixel(32'hA5A5A5A5, 12'd0, 12'd0);
        queue_pixel(32'h5A5A5A5A, 12'hFFF, 12'hFFF);

        // Directed corners, edge bands, the middle and far off-frame points.
        configure(64, 48, 10);
        queue_pixel(32'hFFFFFFFF, 12'd0, 12'd0);
        queue_pixel(32'h00FF0000, 12'd63, 12'd0);
        queue_pixel(32'h0000FF00, 12'd0, 12'd47);
        queue_pixel(32'h000000FF, 12'd63, 12'd47);
        queue_pixel(32'hFFFFFFFF, 12'd9, 12'd9);
        queue_pixel(32'h80808080, 12'd10, 12'd0);
        queue_pixel(32'h00FFFFFF, 12'd5, 12'd5);
        queue_pixel(32'h00000000, 12'd2, 12'd2);
        queue_pixel(32'hFFFFFFFF, 12'hFFF, 12'hFFF);
        queue_pixel(32'h0F0F0F0F, 12'hFFF, 12'd0);
        queue_pixel(32'hF0F0F0F0, 12'd0, 12'hFFF);
        queue_pixel(32'h12345678, 12'd32, 12'd24);
        queue_pixel(32'hFF807F01, 12'd3, 12'd7);
        queue_pixel(32'h00FFFFFF, 12'd60, 12'd44);

        // Random phases over oversized, zero, clamped, tiny and ordinary frames.
        run_phase(8191, 8191, 4095, 128, 1'b1);
        run_phase(0, 100, 20, 128, 1'b0);
        run_phase(100, 0, 4095, 128, 1'b0);
        run_phase(16, 16, 4095, 128, 1'b0);
        run_phase(2, 3, 1, 128, 1'b0);
        run_phase(4096, 1, 5, 128, 1'b0);
        run_phase(640, 480, 32, 128, 1'b1);
        run_phase(100, 7, 3, 128, 1'b0);
        run_phase(4095, 4096, 2047, 128, 1'b0);
        run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 40),
                  128, 1'b0);
        run_phase($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 4095),
                  128, 1'b0);
        run_phase(5000, 12, 4095, 128, 1'b0);

        wait_drained();
        $display("Sent %0d pixel beats across %0d frame geometries, including long output holds.",
                 beats_in, settings_done);
        $display("Checked %0d masked pixels, %0d partly covered corners, %0d mismatches.",
                 results_checked, partial_results, errors);
        if (errors == 0)
            $display("tb_rounded_corner_alpha_mask_core OK");
        else
            $display("tb_rounded_corner_alpha_mask_core NOT OK");
        $finish;
    end

endmodule
